[rtl/bqrc_pkg.sv]
`default_nettype none
package bqrc_pkg;

    localparam int FRAC_BITS       = 28;
    localparam int KB_WIDTH        = 29;
    localparam int ACC_WIDTH       = 64;
    localparam int PC_WIDTH        = 4;
    localparam int CFG_INDEX_WIDTH = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0      = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1      = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2      = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1      = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2      = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_MIN = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_MAX = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KB      = 4'd7;

    localparam logic [KB_WIDTH-1:0] KB_RESET = {1'b1, {(KB_WIDTH-1){1'b0}}};

    localparam logic [1:0] SAT_NONE  = 2'd0;
    localparam logic [1:0] SAT_UPPER = 2'd1;
    localparam logic [1:0] SAT_LOWER = 2'd2;

    typedef enum logic [2:0] {
        ASEL_B0, ASEL_B1, ASEL_B2, ASEL_A1, ASEL_A2, ASEL_KB
    } t_asel;

    typedef enum logic [2:0] {
        BSEL_X, BSEL_X1, BSEL_X2, BSEL_Y1, BSEL_Y2, BSEL_DIFF
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc;

    typedef enum logic [2:0] {
        OP_NONE, OP_ACCEPT, OP_ROUND, OP_RAW, OP_CLAMP, OP_DIFF, OP_FB, OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_NO_IN, JMP_OUT_BUSY
    } t_jmp;

    typedef struct packed {
        logic mul_en;
        t_acc acc;
    } t_mac_ctrl;

    typedef struct packed {
        t_asel                asel;
        t_bsel                bsel;
        t_mac_ctrl            mac;
        t_op                  op;
        t_jmp                 jmp;
        logic [PC_WIDTH-1:0]  target;
    } t_ctrl;

    function automatic t_ctrl cw(t_asel a, t_bsel b, logic mul, t_acc acc, t_op op,
                                 t_jmp j, logic [PC_WIDTH-1:0] tgt);
        t_ctrl w;
        w.asel       = a;
        w.bsel       = b;
        w.mac.mul_en = mul;
        w.mac.acc    = acc;
        w.op         = op;
        w.jmp        = j;
        w.target     = tgt;
        return w;
    endfunction

    // Microprogram. The multiplier output is registered, so each accumulate
    // lands in the step after its multiply.
    function automatic t_ctrl prog_word(logic [PC_WIDTH-1:0] pc);
        t_ctrl w;
        case (pc)
            4'd0:  w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_ACCEPT, JMP_NO_IN, 4'd0);
            4'd1:  w = cw(ASEL_B0, BSEL_X,    1'b1, ACC_HOLD, OP_NONE,   JMP_NEXT,  4'd0);
            4'd2:  w = cw(ASEL_B1, BSEL_X1,   1'b1, ACC_LOAD, OP_NONE,   JMP_NEXT,  4'd0);
            4'd3:  w = cw(ASEL_B2, BSEL_X2,   1'b1, ACC_ADD,  OP_NONE,   JMP_NEXT,  4'd0);
            4'd4:  w = cw(ASEL_A1, BSEL_Y1,   1'b1, ACC_ADD,  OP_NONE,   JMP_NEXT,  4'd0);
            4'd5:  w = cw(ASEL_A2, BSEL_Y2,   1'b1, ACC_SUB,  OP_NONE,   JMP_NEXT,  4'd0);
            4'd6:  w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_SUB,  OP_NONE,   JMP_NEXT,  4'd0);
            4'd7:  w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_ROUND,  JMP_NEXT,  4'd0);
            4'd8:  w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_RAW,    JMP_NEXT,  4'd0);
            4'd9:  w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_CLAMP,  JMP_NEXT,  4'd0);
            4'd10: w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_DIFF,   JMP_NEXT,  4'd0);
            4'd11: w = cw(ASEL_KB, BSEL_DIFF, 1'b1, ACC_HOLD, OP_NONE,   JMP_NEXT,  4'd0);
            4'd12: w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_LOAD, OP_NONE,   JMP_NEXT,  4'd0);
            4'd13: w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_ROUND,  JMP_NEXT,  4'd0);
            4'd14: w = cw(ASEL_B0, BSEL_X,    1'b0, ACC_HOLD, OP_FB,     JMP_NEXT,  4'd0);
            // last step: hold until the output register is free, then wrap to 0
            default: w = cw(ASEL_B0, BSEL_X, 1'b0, ACC_HOLD, OP_OUT, JMP_OUT_BUSY, 4'd15);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/biquad_resonant_controller_antiwindup.sv]
`default_nettype none
// Biquad resonant controller with output limiting and back-calculation anti-windup.
// Input channel (i_in_valid / o_in_ready) takes one error word plus a limit enable.
// Output channel (o_out_valid / i_out_ready) returns the drive word and the
// saturation status (0 none, 1 upper, 2 lower) for each input word.
// A 16-step microprogram runs one shared multiplier: five MACs for the biquad,
// rounding and saturation, the clamp, and one more multiply for the anti-windup
// correction. A word is accepted at step 0 and its result is loaded into the
// output register at step 15; the next word can be accepted on the following
// cycle, so a new word is taken only once the last one is through.
// The result stays in the output register until taken; meanwhile the next word
// is accepted and computed, and the final step waits only if the previous
// result is still held when the new one is ready.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, one
// register per cycle; the user must write only while no word is in flight,
// which the block does not enforce. Synchronous active-low reset clears the
// filter history, restores the register defaults and empties the output register.
module biquad_resonant_controller_antiwindup #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_in_valid,
    output logic                                             o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]              i_error_sample,
    input  wire logic                                        i_limit_enable,
    output logic                                             o_out_valid,
    input  wire logic                                        i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                   o_drive_value,
    output logic [1:0]                                       o_sat_status,
    input  wire logic                                        i_cfg_we,
    input  wire logic [bqrc_pkg::CFG_INDEX_WIDTH-1:0]        i_cfg_index,
    input  wire logic [((COEF_WIDTH > SAMPLE_WIDTH) ?
                       ((COEF_WIDTH > bqrc_pkg::KB_WIDTH) ? COEF_WIDTH : bqrc_pkg::KB_WIDTH) :
                       ((SAMPLE_WIDTH > bqrc_pkg::KB_WIDTH) ? SAMPLE_WIDTH :
                        bqrc_pkg::KB_WIDTH))-1:0]            i_cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int KW   = bqrc_pkg::KB_WIDTH;
    localparam int FB   = bqrc_pkg::FRAC_BITS;
    localparam int AW   = bqrc_pkg::ACC_WIDTH;
    localparam int PCW  = bqrc_pkg::PC_WIDTH;
    localparam int A_W  = (COEF_WIDTH > KW + 1) ? COEF_WIDTH : KW + 1;
    localparam int B_W  = SW + 1;
    localparam int RW   = AW - FB;      // rounded accumulator width
    localparam int SUMW = RW + 1;       // raw plus correction

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [RW-1:0] R_MAX = RW'(S_MAX);
    localparam logic signed [RW-1:0] R_MIN = RW'(S_MIN);
    localparam logic signed [SUMW-1:0] U_MAX = SUMW'(S_MAX);
    localparam logic signed [SUMW-1:0] U_MIN = SUMW'(S_MIN);
    localparam logic signed [AW-1:0] HALF = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    // configuration
    logic signed [COEF_WIDTH-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [SW-1:0]         r_min, r_max;
    logic [KW-1:0]                r_kb;

    // filter history and working registers
    logic signed [SW-1:0]  r_x, r_x1, r_x2, r_y1, r_y2;
    logic                  r_lim;
    logic signed [RW-1:0]  r_rnd;
    logic signed [SW-1:0]  r_raw, r_drive, r_fb;
    logic [1:0]            r_status;
    logic signed [B_W-1:0] r_diff;

    logic [PCW-1:0] r_pc, n_pc;
    logic           r_out_valid;
    logic signed [SW-1:0] r_out_drive;
    logic [1:0]     r_out_status;

    bqrc_pkg::t_ctrl      ctrl;
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [AW-1:0]  acc;
    logic signed [AW-1:0]  acc_half;
    logic signed [SUMW-1:0] fb_sum;
    logic                  out_busy;
    logic                  jump;
    logic                  commit;

    assign ctrl     = bqrc_pkg::prog_word(r_pc);
    assign out_busy = r_out_valid && !i_out_ready;
    assign commit   = (ctrl.op == bqrc_pkg::OP_OUT) && !out_busy;

    always_comb begin
        case (ctrl.asel)
            bqrc_pkg::ASEL_B1: mul_a = A_W'(r_b1);
            bqrc_pkg::ASEL_B2: mul_a = A_W'(r_b2);
            bqrc_pkg::ASEL_A1: mul_a = A_W'(r_a1);
            bqrc_pkg::ASEL_A2: mul_a = A_W'(r_a2);
            bqrc_pkg::ASEL_KB: mul_a = A_W'(signed'({1'b0, r_kb}));
            default:           mul_a = A_W'(r_b0);
        endcase
        case (ctrl.bsel)
            bqrc_pkg::BSEL_X1:   mul_b = B_W'(r_x1);
            bqrc_pkg::BSEL_X2:   mul_b = B_W'(r_x2);
            bqrc_pkg::BSEL_Y1:   mul_b = B_W'(r_y1);
            bqrc_pkg::BSEL_Y2:   mul_b = B_W'(r_y2);
            bqrc_pkg::BSEL_DIFF: mul_b = r_diff;
            default:             mul_b = B_W'(r_x);
        endcase
    end

    bqrc_mac #(
        .A_WIDTH (A_W),
        .B_WIDTH (B_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (ctrl.mac),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_acc  (acc)
    );

    // round half up: add half an LSB, then floor
    assign acc_half = acc + HALF;
    assign fb_sum   = SUMW'(r_raw) + SUMW'(r_rnd);

    always_comb begin
        unique case (ctrl.jmp)
            bqrc_pkg::JMP_NO_IN:    jump = !i_in_valid;
            bqrc_pkg::JMP_OUT_BUSY: jump = out_busy;
            default:                jump = 1'b0;
        endcase
        n_pc = jump ? ctrl.target : r_pc + PCW'(1);
    end

    assign o_in_ready = (ctrl.op == bqrc_pkg::OP_ACCEPT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            r_b0        <= '0;
            r_b1        <= '0;
            r_b2        <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
            r_min       <= S_MIN;
            r_max       <= S_MAX;
            r_kb        <= bqrc_pkg::KB_RESET;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bqrc_pkg::REG_B0:      r_b0  <= i_cfg_data[COEF_WIDTH-1:0];
                    bqrc_pkg::REG_B1:      r_b1  <= i_cfg_data[COEF_WIDTH-1:0];
                    bqrc_pkg::REG_B2:      r_b2  <= i_cfg_data[COEF_WIDTH-1:0];
                    bqrc_pkg::REG_A1:      r_a1  <= i_cfg_data[COEF_WIDTH-1:0];
                    bqrc_pkg::REG_A2:      r_a2  <= i_cfg_data[COEF_WIDTH-1:0];
                    bqrc_pkg::REG_OUT_MIN: r_min <= i_cfg_data[SW-1:0];
                    bqrc_pkg::REG_OUT_MAX: r_max <= i_cfg_data[SW-1:0];
                    bqrc_pkg::REG_KB:      r_kb  <= i_cfg_data[KW-1:0];
                    default: ;
                endcase
            end
            if (commit) begin
                r_x2        <= r_x1;
                r_x1        <= r_x;
                r_y2        <= r_y1;
                r_y1        <= r_fb;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            bqrc_pkg::OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_x   <= i_error_sample;
                    r_lim <= i_limit_enable;
                end
            end
            bqrc_pkg::OP_ROUND: r_rnd <= acc_half[AW-1:FB];
            bqrc_pkg::OP_RAW: begin
                if (r_rnd > R_MAX) begin
                    r_raw <= S_MAX;
                end else if (r_rnd < R_MIN) begin
                    r_raw <= S_MIN;
                end else begin
                    r_raw <= r_rnd[SW-1:0];
                end
            end
            bqrc_pkg::OP_CLAMP: begin
                // upper limit checked first, so inverted limits favor out_max
                if (r_lim && (r_raw > r_max)) begin
                    r_drive  <= r_max;
                    r_status <= bqrc_pkg::SAT_UPPER;
                end else if (r_lim && (r_raw < r_min)) begin
                    r_drive  <= r_min;
                    r_status <= bqrc_pkg::SAT_LOWER;
                end else begin
                    r_drive  <= r_raw;
                    r_status <= bqrc_pkg::SAT_NONE;
                end
            end
            // without limiting the difference is zero, so fb comes out as raw
            bqrc_pkg::OP_DIFF: r_diff <= B_W'(r_drive) - B_W'(r_raw);
            bqrc_pkg::OP_FB: begin
                if (fb_sum > U_MAX) begin
                    r_fb <= S_MAX;
                end else if (fb_sum < U_MIN) begin
                    r_fb <= S_MIN;
                end else begin
                    r_fb <= fb_sum[SW-1:0];
                end
            end
            bqrc_pkg::OP_OUT: begin
                if (!out_busy) begin
                    r_out_drive  <= r_drive;
                    r_out_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_out_drive;
    assign o_sat_status  = r_out_status;

endmodule
`default_nettype wire

[rtl/bqrc_mac.sv]
`default_nettype none
module bqrc_mac #(
    parameter int A_WIDTH = 32,
    parameter int B_WIDTH = 25
) (
    input  wire logic                                     i_clk,
    input  wire bqrc_pkg::t_mac_ctrl                      i_ctrl,
    input  wire logic signed [A_WIDTH-1:0]                i_a,
    input  wire logic signed [B_WIDTH-1:0]                i_b,
    output logic signed [bqrc_pkg::ACC_WIDTH-1:0]         o_acc
);

    localparam int AW = bqrc_pkg::ACC_WIDTH;
    localparam int PW = A_WIDTH + B_WIDTH;

    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] prod_ext;

    // sign-extends, or wraps modulo 2^64 when the product is wider
    assign prod_ext = AW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= PW'(i_a) * PW'(i_b);
        end
        case (i_ctrl.acc)
            bqrc_pkg::ACC_LOAD: r_acc <= prod_ext;
            bqrc_pkg::ACC_ADD:  r_acc <= r_acc + prod_ext;
            bqrc_pkg::ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:            r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire
